### rtl/sepc_pkg.sv
// Shared types, constants and helpers for the stepper encoder position correction block.
// Used by sepc_ctrl, sepc_datapath and the top level; depends on nothing else.
`timescale 1ns / 1ps

package sepc_pkg;

    // fixed widths of the position and encoder words
    localparam int POSITION_BITS = 32;
    localparam int ENCODER_BITS  = 16;

    // dividend of the count-to-step division: raw count times steps per revolution
    localparam int DIV_W   = ENCODER_BITS + 16;
    localparam int DCNT_W  = $clog2(DIV_W);

    // encoder counts per revolution, clamped range
    localparam int CNT_W = 17;
    localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(65536);

    // wide signed values that get saturated to the position width
    localparam int WIDE_W = 51;
    localparam logic signed [WIDE_W-1:0] POS_HI = WIDE_W'((64'd1 << (POSITION_BITS - 1)) - 64'd1);
    localparam logic signed [WIDE_W-1:0] POS_LO = -POS_HI - WIDE_W'(1);

    // configuration register indexes
    localparam logic [2:0] REG_STEPS_PER_REV   = 3'd0;
    localparam logic [2:0] REG_ENCODER_COUNTS  = 3'd1;
    localparam logic [2:0] REG_CORR_THRESHOLD  = 3'd2;
    localparam logic [2:0] REG_CORR_LIMIT      = 3'd3;
    localparam logic [2:0] REG_INITIAL_SYNC    = 3'd4;
    localparam logic [2:0] REG_SETTLE_WINDOW   = 3'd5;
    localparam logic [2:0] REG_AUTO_DISABLE    = 3'd6;

    // action codes of a result
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_SYNC    = 3'd1;
    localparam logic [2:0] ACT_RESYNC  = 3'd2;
    localparam logic [2:0] ACT_CORRECT = 3'd3;
    localparam logic [2:0] ACT_DISABLE = 3'd4;
    localparam logic [2:0] ACT_BELOW   = 3'd5;
    localparam logic [2:0] ACT_NOISE   = 3'd6;
    localparam logic [2:0] ACT_HOLD    = 3'd7;

    typedef struct packed {
        logic [15:0] steps_per_rev;
        logic [16:0] encoder_counts;
        logic [15:0] correction_threshold;
        logic [19:0] corr_limit;
        logic        initial_sync;
        logic [31:0] settle_window_ms;
        logic        auto_disable;
    } cfg_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic latch_in;
        logic do_turn;
        logic do_mult;
        logic do_div;
        logic do_conv;
        logic do_decide;
    } ctrl_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic div_done;
    } ctrl_stat_t;

    typedef struct packed {
        logic [2:0]                       action;
        logic signed [POSITION_BITS-1:0]  new_position;
        logic signed [POSITION_BITS-1:0]  position_error;
        logic                             error_valid;
        logic                             motor_enabled;
    } result_t;

    // saturate a wide signed value to the position width
    function automatic logic signed [POSITION_BITS-1:0] sat_pos(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] r;
        begin
            if (v > POS_HI)
            begin
                r = POS_HI;
            end
            else if (v < POS_LO)
            begin
                r = POS_LO;
            end
            else
            begin
                r = v;
            end
            return r[POSITION_BITS-1:0];
        end
    endfunction

endpackage

### rtl/stepper_encoder_position_correction_core.sv
// Top level of the stepper encoder position correction block: configuration
// registers, output register and the controller/datapath pair.
// Depends on sepc_pkg, sepc_ctrl and sepc_datapath.
`timescale 1ns / 1ps

// Usage
//   Input stream s_*: one transfer per encoder sample carrying the raw encoder
//   count, the motor's step position and target, and the millisecond time.
//   Output stream m_*: exactly one transfer per sample with the action, the
//   position to write back, the step error and the enable status.
//   Configuration: cfg_we writes cfg_data to register cfg_addr;
//   write only while no sample is in flight.
// Processing
//   A sample goes through the turn update, the multiplies, the 32-step
//   bit-serial division of count times steps per revolution by the encoder
//   counts, the conversion and the decision into the output register. A new
//   sample is taken only once the last one has reached the output register.
// Reset and stalls
//   rst_n clears the tracking state and loads the register defaults; the first
//   sample after reset performs the initial sync. A finished result waits in
//   the output register while m_tready is low; the next sample is still taken
//   and worked on, and its decision waits until the register is free.
module stepper_encoder_position_correction_core (
    input  logic         clk,
    input  logic         rst_n,
    // configuration write port
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_data,
    // sample stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,  // encoder_position[15:0], motor_position[47:16],
                                   // goal_position[79:48], now_ms[111:80]
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,  // new_position[31:0], position_error[63:32],
                                   // motor_enabled[64], zero fill[71:65]
    output logic [3:0]   m_tuser   // action[2:0], error_valid[3]
);
    import sepc_pkg::*;

    cfg_t       cfg_reg;
    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;
    result_t    result;
    result_t    out_reg;
    logic       out_valid_reg;
    logic       out_free;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.steps_per_rev        <= 16'd200;
            cfg_reg.encoder_counts       <= 17'd4096;
            cfg_reg.correction_threshold <= 16'd2;
            cfg_reg.corr_limit           <= 20'd1000;
            cfg_reg.initial_sync         <= 1'b1;
            cfg_reg.settle_window_ms     <= 32'd500;
            cfg_reg.auto_disable         <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_STEPS_PER_REV:  cfg_reg.steps_per_rev        <= cfg_data[15:0];
                REG_ENCODER_COUNTS: cfg_reg.encoder_counts       <= cfg_data[16:0];
                REG_CORR_THRESHOLD: cfg_reg.correction_threshold <= cfg_data[15:0];
                REG_CORR_LIMIT:     cfg_reg.corr_limit           <= cfg_data[19:0];
                REG_INITIAL_SYNC:   cfg_reg.initial_sync         <= cfg_data[0];
                REG_SETTLE_WINDOW:  cfg_reg.settle_window_ms     <= cfg_data;
                REG_AUTO_DISABLE:   cfg_reg.auto_disable         <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    sepc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .stat     (stat),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    sepc_datapath u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg                 (cfg_reg),
        .in_encoder_position (s_tdata[15:0]),
        .in_motor_position   (signed'(s_tdata[47:16])),
        .in_goal_position    (signed'(s_tdata[79:48])),
        .in_now_ms           (s_tdata[111:80]),
        .cmd                 (cmd),
        .stat                (stat),
        .result              (result)
    );

    // output register, loaded by the decision step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.do_decide)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_decide)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_reg.motor_enabled, out_reg.position_error,
                       out_reg.new_position};
    assign m_tuser  = {out_reg.error_valid, out_reg.action};

endmodule

### rtl/sepc_ctrl.sv
// Sequencing state machine of the position correction block.
// Depends on sepc_pkg for the command and status structs.
`timescale 1ns / 1ps

module sepc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  out_free,
    input  sepc_pkg::ctrl_stat_t  stat,
    output logic                  in_ready,
    output sepc_pkg::ctrl_cmd_t   cmd
);
    import sepc_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_TURN   = 3'd1;
    localparam logic [2:0] S_MULT   = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_CONV   = 3'd4;
    localparam logic [2:0] S_DECIDE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_TURN;
                end
            end
            S_TURN:
            begin
                cmd.do_turn = 1'b1;
                state_next  = S_MULT;
            end
            S_MULT:
            begin
                cmd.do_mult = 1'b1;
                state_next  = S_DIV;
            end
            S_DIV:
            begin
                cmd.do_div = 1'b1;
                if (stat.div_done)
                begin
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                cmd.do_conv = 1'b1;
                state_next  = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (out_free)
                begin
                    cmd.do_decide = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // checks
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch_in |=> state_reg == S_TURN)
        else $error("accepted sample did not start the turn update");

    a_div_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && !stat.div_done) |=> state_reg == S_DIV)
        else $error("left the division before it finished");

    a_out_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && !out_free) |=> state_reg == S_DECIDE)
        else $error("decision taken while the output register was full");

endmodule

### rtl/sepc_datapath.sv
// Datapath of the position correction block: turn counter, multipliers,
// bit-serial divider, step conversion and correction decision with its state.
// Depends on sepc_pkg; driven by commands from sepc_ctrl.
`timescale 1ns / 1ps

module sepc_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  sepc_pkg::cfg_t                         cfg,
    input  logic [15:0]                            in_encoder_position,
    input  logic signed [sepc_pkg::POSITION_BITS-1:0] in_motor_position,
    input  logic signed [sepc_pkg::POSITION_BITS-1:0] in_goal_position,
    input  logic [31:0]                            in_now_ms,
    input  sepc_pkg::ctrl_cmd_t                    cmd,
    output sepc_pkg::ctrl_stat_t                   stat,
    output sepc_pkg::result_t                      result
);
    import sepc_pkg::*;

    // sample registers
    logic [ENCODER_BITS-1:0]         enc_reg;
    logic signed [POSITION_BITS-1:0] motor_reg;
    logic signed [POSITION_BITS-1:0] target_reg;
    logic [31:0]                     now_reg;

    // persistent state
    logic                            started_reg;
    logic [ENCODER_BITS-1:0]         prev_reg;
    logic [31:0]                     turns_reg;
    logic [31:0]                     turns_next;
    logic                            disabled_reg;
    logic                            disabled_next;
    logic                            was_at_goal_reg;
    logic                            was_at_goal_next;
    logic [31:0]                     goal_time_reg;
    logic [31:0]                     goal_time_next;
    logic signed [POSITION_BITS-1:0] rem_target_reg;
    logic signed [POSITION_BITS-1:0] rem_target_next;

    // conversion pipeline
    logic signed [48:0]              tspr_reg;
    logic signed [49:0]              tc_reg;
    logic [DIV_W-1:0]                quo_reg;
    logic [CNT_W-1:0]                rem_reg;
    logic [DCNT_W-1:0]               dcnt_reg;
    logic                            neg_reg;
    logic signed [POSITION_BITS-1:0] actual_reg;

    logic [CNT_W-1:0]                cnt_eff;
    logic signed [18:0]              delta2;
    logic signed [18:0]              cnt_s;
    logic [CNT_W:0]                  shifted;
    logic [CNT_W+1:0]                trial;
    logic signed [WIDE_W-1:0]        abs_sum;
    logic [32:0]                     q_adj;
    logic signed [WIDE_W-1:0]        conv_sum;
    logic signed [32:0]              full;
    logic [32:0]                     mag;
    logic                            at_goal;
    logic [31:0]                     elapsed;
    logic                            held;

    // effective encoder counts per revolution
    always_comb
    begin
        priority if (cfg.encoder_counts < CNT_MIN)
        begin
            cnt_eff = CNT_MIN;
        end
        else if (cfg.encoder_counts > CNT_MAX)
        begin
            cnt_eff = CNT_MAX;
        end
        else
        begin
            cnt_eff = cfg.encoder_counts;
        end
    end

    // wrap detection: twice the jump against one revolution
    always_comb
    begin
        delta2 = (19'(signed'({1'b0, enc_reg})) - 19'(signed'({1'b0, prev_reg}))) <<< 1;
        cnt_s  = signed'({2'b00, cnt_eff});
        turns_next = turns_reg;
        if (started_reg)
        begin
            priority if (delta2 > cnt_s)
            begin
                turns_next = turns_reg - 32'd1;
            end
            else if (delta2 < -cnt_s)
            begin
                turns_next = turns_reg + 32'd1;
            end
        end
    end

    // one restoring division step, and sign of the absolute count
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIV_W-1]};
        trial   = {1'b0, shifted} - {2'b00, cnt_eff};
        abs_sum = WIDE_W'(tc_reg) + WIDE_W'(signed'({1'b0, enc_reg}));
    end

    assign stat.div_done = (dcnt_reg == DCNT_W'(DIV_W - 1));

    // conversion: turns*steps plus the quotient, rounded up when the absolute count is negative
    always_comb
    begin
        q_adj    = 33'(quo_reg) + 33'(neg_reg && (rem_reg != '0));
        conv_sum = WIDE_W'(tspr_reg) + WIDE_W'(signed'({1'b0, q_adj}));
    end

    // correction decision
    always_comb
    begin
        full    = 33'(actual_reg) - 33'(motor_reg);
        mag     = full[32] ? 33'(-full) : 33'(full);
        at_goal = (motor_reg == target_reg);
        goal_time_next   = goal_time_reg;
        was_at_goal_next = was_at_goal_reg;
        disabled_next    = disabled_reg;
        rem_target_next  = rem_target_reg;
        elapsed = '0;
        held    = 1'b0;
        result  = '0;
        result.action = ACT_NONE;

        priority if (!started_reg)
        begin
            if (cfg.initial_sync)
            begin
                result.action       = ACT_SYNC;
                result.new_position = actual_reg;
                rem_target_next     = actual_reg;
            end
            else
            begin
                rem_target_next = target_reg;
            end
        end
        else if (disabled_reg)
        begin
            if (target_reg != rem_target_reg)
            begin
                result.action       = ACT_RESYNC;
                result.new_position = actual_reg;
                disabled_next       = 1'b0;
                was_at_goal_next    = 1'b0;
                rem_target_next     = target_reg;
            end
        end
        else
        begin
            result.position_error = sat_pos(WIDE_W'(full));
            result.error_valid    = 1'b1;
            if (at_goal && !was_at_goal_reg)
            begin
                goal_time_next = now_reg;
            end
            was_at_goal_next = at_goal;
            elapsed = now_reg - goal_time_next;
            held    = at_goal && (elapsed > cfg.settle_window_ms);
            if (held)
            begin
                if (cfg.auto_disable)
                begin
                    result.action   = ACT_DISABLE;
                    disabled_next   = 1'b1;
                    rem_target_next = target_reg;
                end
                else
                begin
                    result.action = ACT_HOLD;
                end
            end
            else
            begin
                priority if (mag <= 33'(cfg.correction_threshold))
                begin
                    result.action = ACT_BELOW;
                end
                else if (mag > 33'(cfg.corr_limit))
                begin
                    result.action = ACT_NOISE;
                end
                else
                begin
                    result.action       = ACT_CORRECT;
                    result.new_position = actual_reg;
                end
            end
        end
        result.motor_enabled = !disabled_next;
    end

    // sample capture and conversion pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            enc_reg    <= in_encoder_position[ENCODER_BITS-1:0];
            motor_reg  <= in_motor_position;
            target_reg <= in_goal_position;
            now_reg    <= in_now_ms;
        end
        if (cmd.do_mult)
        begin
            tspr_reg <= 49'(signed'(turns_reg)) * 49'(signed'({1'b0, cfg.steps_per_rev}));
            tc_reg   <= 50'(signed'(turns_reg)) * 50'(signed'({1'b0, cnt_eff}));
            quo_reg  <= DIV_W'(enc_reg) * DIV_W'(cfg.steps_per_rev);
            rem_reg  <= '0;
        end
        if (cmd.do_div)
        begin
            neg_reg <= abs_sum[WIDE_W-1];
            if (!trial[CNT_W+1])
            begin
                rem_reg <= trial[CNT_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[CNT_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
        if (cmd.do_conv)
        begin
            actual_reg <= sat_pos(conv_sum);
        end
    end

    // division step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.do_mult)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.do_div)
        begin
            dcnt_reg <= dcnt_reg + DCNT_W'(1);
        end
    end

    // persistent tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg     <= 1'b0;
            prev_reg        <= '0;
            turns_reg       <= '0;
            disabled_reg    <= 1'b0;
            was_at_goal_reg <= 1'b0;
            goal_time_reg   <= '0;
            rem_target_reg  <= '0;
        end
        else
        begin
            if (cmd.do_turn)
            begin
                turns_reg <= turns_next;
                prev_reg  <= enc_reg;
            end
            if (cmd.do_decide)
            begin
                started_reg     <= 1'b1;
                disabled_reg    <= disabled_next;
                was_at_goal_reg <= was_at_goal_next;
                goal_time_reg   <= goal_time_next;
                rem_target_reg  <= rem_target_next;
            end
        end
    end

    // checks
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_conv |-> rem_reg < cnt_eff)
        else $error("division remainder not below the divisor");

    a_disabled_started: assert property (@(posedge clk) disable iff (!rst_n)
        disabled_reg |-> started_reg)
        else $error("motor disabled before the first sample");

    a_decide_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_decide |=> started_reg)
        else $error("first decision did not mark tracking as started");

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for stepper_encoder_position_correction_core.
// Holds its own position-correction predictor and checks every output transfer.
// Depends on sepc_pkg and the core RTL only.
`timescale 1ns / 1ps

module testbench;

    import sepc_pkg::*;

    localparam longint POS_MAX     = 64'sd2147483647;
    localparam longint POS_MIN     = -64'sd2147483648;
    localparam int     CYCLE_LIMIT = 600000;
    localparam int     DRAIN_WAIT  = 40;
    localparam int     HOLD_CYCLES = 400;
    localparam int     PHASES      = 8;
    localparam int     PHASE_ITEMS = 82;

    // one row of the directed part: a register write or a sample
    typedef struct {
        bit           is_cfg;
        logic [2:0]   addr;
        logic [31:0]  data;
        logic [111:0] sample;
        bit           typed;
        result_t      want;
    } dir_row_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [2:0]   cfg_addr;
    logic [31:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;   // encoder_position, motor_position, goal_position, now_ms
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;   // new_position, position_error, motor_enabled, zero fill
    logic [3:0]   m_tuser;   // action, error_valid

    // predictor copy of registers and tracking state
    cfg_t         regs;
    bit           trk_started;
    logic [15:0]  prev_enc;
    logic [31:0]  turn_count;
    bit           motor_off;
    bit           at_goal_prev;
    logic [31:0]  goal_time;
    longint       held_target;

    // results still owed by the block, oldest first
    result_t      pending_results[$];

    int           mismatches;
    int           cycle_count;
    int           idle_pct;
    int           stall_pct;
    bit           hold_req;

    // generator state of the well-formed samples
    longint       gen_pos;
    longint       last_actual;
    logic [31:0]  gen_target;
    logic [31:0]  gen_now;
    bit           gen_at;

    stepper_encoder_position_correction_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("stepper_encoder_position_correction_core: mismatch");
            $finish;
        end
    end

    function automatic longint clamp_pos(input longint v);
        begin
            if (v > POS_MAX)
            begin
                return POS_MAX;
            end
            if (v < POS_MIN)
            begin
                return POS_MIN;
            end
            return v;
        end
    endfunction

    // counts per revolution as the block uses them
    function automatic longint eff_counts();
        longint c;
        begin
            c = longint'(regs.encoder_counts);
            if (c < 2)
            begin
                c = 2;
            end
            else if (c > 65536)
            begin
                c = 65536;
            end
            return c;
        end
    endfunction

    // absolute encoder count to motor steps, truncated toward zero
    function automatic longint enc_to_steps(input logic [15:0] pos);
        longint c;
        longint prod;
        begin
            c = eff_counts();
            prod = (longint'(signed'(turn_count)) * c + longint'(pos))
                   * longint'(regs.steps_per_rev);
            return clamp_pos(prod / c);
        end
    endfunction

    // expected result of one sample; advances the tracking state
    function automatic result_t predict_correction(input logic [111:0] d);
        logic [15:0] enc;
        longint      motor;
        longint      target;
        logic [31:0] now;
        logic [31:0] elapsed;
        longint      c;
        longint      delta;
        longint      actual;
        longint      full;
        longint      mag;
        longint      newpos;
        longint      err;
        logic [2:0]  act;
        bit          valid;
        bit          at;
        bit          held;
        result_t     r;
        begin
            enc    = d[15:0];
            motor  = longint'(signed'(d[47:16]));
            target = longint'(signed'(d[79:48]));
            now    = d[111:80];
            act    = ACT_NONE;
            newpos = 0;
            err    = 0;
            valid  = 1'b0;
            if (!trk_started)
            begin
                // first sample: no turn counting
                prev_enc    = enc;
                trk_started = 1'b1;
                if (regs.initial_sync)
                begin
                    newpos      = enc_to_steps(enc);
                    held_target = newpos;
                    act         = ACT_SYNC;
                end
                else
                begin
                    held_target = target;
                end
            end
            else
            begin
                // turn counting on jumps beyond half a revolution
                delta = longint'(enc) - longint'(prev_enc);
                c = eff_counts();
                if (2 * delta > c)
                begin
                    turn_count = turn_count - 32'd1;
                end
                else if (2 * delta < -c)
                begin
                    turn_count = turn_count + 32'd1;
                end
                prev_enc = enc;
                if (motor_off)
                begin
                    // stays off until a new target shows up
                    if (target != held_target)
                    begin
                        newpos       = enc_to_steps(enc);
                        motor_off    = 1'b0;
                        at_goal_prev = 1'b0;
                        held_target  = target;
                        act          = ACT_RESYNC;
                    end
                end
                else
                begin
                    actual = enc_to_steps(enc);
                    full   = actual - motor;
                    mag    = (full < 0) ? -full : full;
                    at     = (motor == target);
                    held   = 1'b0;
                    err    = clamp_pos(full);
                    valid  = 1'b1;
                    if (at && !at_goal_prev)
                    begin
                        goal_time = now;
                    end
                    at_goal_prev = at;
                    elapsed = now - goal_time;
                    // settle window over while at target
                    if (at && (elapsed > regs.settle_window_ms))
                    begin
                        held = 1'b1;
                        if (regs.auto_disable)
                        begin
                            motor_off   = 1'b1;
                            held_target = target;
                            act         = ACT_DISABLE;
                        end
                        else
                        begin
                            act = ACT_HOLD;
                        end
                    end
                    if (!held)
                    begin
                        if (mag <= longint'(regs.correction_threshold))
                        begin
                            act = ACT_BELOW;
                        end
                        else if (mag > longint'(regs.corr_limit))
                        begin
                            act = ACT_NOISE;
                        end
                        else
                        begin
                            newpos = actual;
                            act    = ACT_CORRECT;
                        end
                    end
                end
            end
            r.action         = act;
            r.new_position   = 32'(newpos);
            r.position_error = 32'(err);
            r.error_valid    = valid;
            r.motor_enabled  = !motor_off;
            return r;
        end
    endfunction

    function automatic logic [111:0] pack_sample(input logic [15:0] enc,
                                                 input logic [31:0] motor,
                                                 input logic [31:0] target,
                                                 input logic [31:0] now);
        begin
            return {now, target, motor, enc};
        end
    endfunction

    function automatic dir_row_t cfg_row(input logic [2:0] a, input logic [31:0] v);
        dir_row_t row;
        begin
            row = '{default: '0};
            row.is_cfg = 1'b1;
            row.addr   = a;
            row.data   = v;
            return row;
        end
    endfunction

    function automatic dir_row_t smp_row(input logic [15:0] enc, input logic [31:0] motor,
                                         input logic [31:0] target, input logic [31:0] now);
        dir_row_t row;
        begin
            row = '{default: '0};
            row.sample = pack_sample(enc, motor, target, now);
            return row;
        end
    endfunction

    function automatic dir_row_t chk_row(input logic [15:0] enc, input logic [31:0] motor,
                                         input logic [31:0] target, input logic [31:0] now,
                                         input logic [2:0] act, input logic [31:0] newpos,
                                         input logic [31:0] err, input bit valid,
                                         input bit en);
        dir_row_t row;
        begin
            row = smp_row(enc, motor, target, now);
            row.typed               = 1'b1;
            row.want.action         = act;
            row.want.new_position   = newpos;
            row.want.position_error = err;
            row.want.error_valid    = valid;
            row.want.motor_enabled  = en;
            return row;
        end
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        begin
            $display("%0t: %s got %h expected %h", $time, field, got, want);
            mismatches = mismatches + 1;
        end
    endtask

    // register write, called at a falling edge; returns at a falling edge with cfg_we low again
    task automatic write_reg(input logic [2:0] a, input logic [31:0] v);
        begin
            cfg_we   <= 1'b1;
            cfg_addr <= a;
            cfg_data <= v;
            @(negedge clk);
            cfg_we <= 1'b0;
            case (a)
                REG_STEPS_PER_REV:  regs.steps_per_rev        = v[15:0];
                REG_ENCODER_COUNTS: regs.encoder_counts       = v[16:0];
                REG_CORR_THRESHOLD: regs.correction_threshold = v[15:0];
                REG_CORR_LIMIT:     regs.corr_limit           = v[19:0];
                REG_INITIAL_SYNC:   regs.initial_sync         = v[0];
                REG_SETTLE_WINDOW:  regs.settle_window_ms     = v;
                REG_AUTO_DISABLE:   regs.auto_disable         = v[0];
                default: ;
            endcase
            @(negedge clk);
        end
    endtask

    // one sample transfer; starts and ends at a falling edge
    task automatic send_sample(input logic [111:0] d, input result_t want);
        int gap;
        begin
            gap = 0;
            while (gap < 30 && $urandom_range(0, 99) < idle_pct)
            begin
                gap = gap + 1;
            end
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= d;
            @(posedge clk);
            while (!s_tready)
            begin
                @(posedge clk);
            end
            pending_results.push_back(want);
            @(negedge clk);
        end
    endtask

    // stop offering and wait until every result has come out
    task automatic drain();
        begin
            s_tvalid <= 1'b0;
            while (pending_results.size() != 0)
            begin
                @(negedge clk);
            end
            repeat (DRAIN_WAIT) @(negedge clk);
        end
    endtask

    // random register setting for one phase, sometimes with junk above the width of the narrower registers
    task automatic set_phase_config();
        logic [31:0] junk;
        logic [16:0] counts;
        logic [15:0] spr;
        logic [15:0] thr;
        logic [19:0] maxc;
        logic [31:0] window;
        begin
            junk = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
            case ($urandom_range(0, 7))
                0: counts = 17'($urandom_range(2, 64));
                1: counts = 17'($urandom_range(2, 65536));
                2: counts = 17'd4096;
                3: counts = 17'd65536;
                4: counts = 17'd0;
                5: counts = 17'd1;
                6: counts = 17'h1FFFF;
                default: counts = 17'd360;
            endcase
            case ($urandom_range(0, 3))
                0: spr = 16'($urandom_range(1, 400));
                1: spr = 16'($urandom_range(1, 65535));
                2: spr = 16'd0;
                default: spr = 16'hFFFF;
            endcase
            thr = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 8)) : 16'($urandom);
            if ($urandom_range(0, 9) < 7)
            begin
                maxc = 20'(thr + $urandom_range(0, 2000));
            end
            else
            begin
                maxc = 20'($urandom);
            end
            case ($urandom_range(0, 19))
                0, 1:    window = 32'd0;
                2, 3, 4: window = $urandom;
                default: window = 32'($urandom_range(0, 40));
            endcase
            write_reg(REG_STEPS_PER_REV, {junk[15:0], spr});
            write_reg(REG_ENCODER_COUNTS, {junk[14:0], counts});
            write_reg(REG_CORR_THRESHOLD, {junk[31:16], thr});
            write_reg(REG_CORR_LIMIT, {junk[11:0], maxc});
            write_reg(REG_INITIAL_SYNC, {junk[31:1], 1'($urandom_range(0, 1))});
            write_reg(REG_SETTLE_WINDOW, window);
            write_reg(REG_AUTO_DISABLE, {junk[30:0], 1'($urandom_range(0, 1))});
        end
    endtask

    // random samples: mostly a plausible motion with small errors, some noise
    task automatic run_phase(input int n_items);
        int          i;
        longint      effc;
        longint      span;
        longint      step;
        longint      off;
        bit          fresh;
        logic [15:0] enc;
        logic [31:0] motor;
        logic [31:0] target;
        logic [111:0] d;
        result_t     want;
        begin
            for (i = 0; i < n_items; i++)
            begin
                effc = eff_counts();
                if ($urandom_range(0, 99) < 12)
                begin
                    d = {$urandom, $urandom, $urandom, 16'($urandom)};
                end
                else
                begin
                    // encoder moves a little, now and then a long way
                    span = effc / 8 + 1;
                    if ($urandom_range(0, 9) == 0)
                    begin
                        span = effc;
                    end
                    step = longint'($urandom_range(0, 32'(2 * span))) - span;
                    gen_pos = ((gen_pos + step) % effc + effc) % effc;
                    enc = 16'(gen_pos);
                    if (effc < 65536 && $urandom_range(0, 19) == 0)
                    begin
                        enc = 16'($urandom_range(32'(effc), 65535));
                    end
                    // motor offset around the interesting error magnitudes
                    case ($urandom_range(0, 6))
                        0: off = 0;
                        1: off = longint'($urandom_range(0, 4));
                        2: off = longint'(regs.correction_threshold);
                        3: off = longint'(regs.correction_threshold) + 1;
                        4: off = longint'(regs.corr_limit);
                        5: off = longint'(regs.corr_limit) + 1;
                        default: off = longint'($urandom_range(0, 3000));
                    endcase
                    if ($urandom_range(0, 1) == 1)
                    begin
                        off = -off;
                    end
                    // stretches at target so the settle timer runs out
                    fresh = ($urandom_range(0, 3) == 0);
                    if (fresh)
                    begin
                        gen_at = !gen_at;
                    end
                    if (gen_at && !fresh)
                    begin
                        motor  = gen_target;
                        target = gen_target;
                    end
                    else
                    begin
                        motor  = 32'(last_actual + off);
                        target = gen_at ? motor
                                 : 32'(longint'(signed'(motor))
                                       + longint'($urandom_range(0, 60)) - 30);
                    end
                    if (motor_off && $urandom_range(0, 3) != 0)
                    begin
                        target = 32'(held_target);
                    end
                    gen_target = target;
                    gen_now = gen_now + 32'($urandom_range(0, 12));
                    if ($urandom_range(0, 24) == 0)
                    begin
                        gen_now = gen_now + $urandom;
                    end
                    d = pack_sample(enc, motor, target, gen_now);
                end
                want = predict_correction(d);
                if (want.error_valid)
                begin
                    last_actual = longint'(signed'(d[47:16])) + longint'(want.position_error);
                end
                if (want.action == ACT_SYNC || want.action == ACT_RESYNC
                    || want.action == ACT_CORRECT)
                begin
                    last_actual = longint'(want.new_position);
                end
                send_sample(d, want);
            end
        end
    endtask

    // receiver: random stalls, and a long hold-off on request
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // compare each output transfer with the oldest expected result
    always @(posedge clk)
    begin : result_check
        result_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
            end
            else
            begin
                w = pending_results.pop_front();
                if (m_tuser[2:0] !== w.action)
                begin
                    report_mismatch("action", 32'(m_tuser[2:0]), 32'(w.action));
                end
                if (m_tdata[31:0] !== w.new_position)
                begin
                    report_mismatch("new_position", m_tdata[31:0], w.new_position);
                end
                if (m_tdata[63:32] !== w.position_error)
                begin
                    report_mismatch("position_error", m_tdata[63:32], w.position_error);
                end
                if (m_tuser[3] !== w.error_valid)
                begin
                    report_mismatch("error_valid", 32'(m_tuser[3]), 32'(w.error_valid));
                end
                if (m_tdata[64] !== w.motor_enabled)
                begin
                    report_mismatch("motor_enabled", 32'(m_tdata[64]), 32'(w.motor_enabled));
                end
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        dir_row_t   rows[$];
        result_t    want;
        int         i;
        int         phase;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_addr    = '0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        mismatches  = 0;
        cycle_count = 0;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_req    = 1'b0;
        gen_pos     = 0;
        last_actual = 0;
        gen_target  = '0;
        gen_now     = '0;
        gen_at      = 1'b0;
        regs.steps_per_rev        = 16'd200;
        regs.encoder_counts       = 17'd4096;
        regs.correction_threshold = 16'd2;
        regs.corr_limit           = 20'd1000;
        regs.initial_sync         = 1'b1;
        regs.settle_window_ms     = 32'd500;
        regs.auto_disable         = 1'b0;
        trk_started  = 1'b0;
        prev_enc     = '0;
        turn_count   = '0;
        motor_off    = 1'b0;
        at_goal_prev = 1'b0;
        goal_time    = '0;
        held_target  = 0;

        // directed part under reset defaults, then the register extremes
        // first sample after reset syncs from the encoder
        rows.push_back(chk_row(16'd0, 32'd0, 32'd0, 32'd0, ACT_SYNC, 32'd0, 32'd0, 1'b0, 1'b1));
        // huge positive error saturates and counts as noise
        rows.push_back(chk_row(16'd0, 32'h8000_0000, 32'd0, 32'd1, ACT_NOISE, 32'd0,
                               32'h7FFF_FFFF, 1'b1, 1'b1));
        // no error at all
        rows.push_back(chk_row(16'd0, 32'd0, 32'd5, 32'd2, ACT_BELOW, 32'd0, 32'd0,
                               1'b1, 1'b1));
        // largest negative error
        rows.push_back(smp_row(16'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd3));
        // jump of exactly half a revolution counts no turn
        rows.push_back(smp_row(16'd2048, 32'd0, 32'd1, 32'd4));
        // conversion truncates
        rows.push_back(smp_row(16'd4095, 32'd199, 32'd0, 32'd5));
        // forward wrap
        rows.push_back(smp_row(16'd10, 32'd150, 32'd0, 32'd6));
        // backward wrap, settle timer starts, window edge, then past it
        rows.push_back(smp_row(16'd4000, 32'd195, 32'd195, 32'd1000));
        rows.push_back(smp_row(16'd4000, 32'd195, 32'd195, 32'd1500));
        rows.push_back(smp_row(16'd4000, 32'd195, 32'd195, 32'd1501));
        // raw count above the revolution is used as it is
        rows.push_back(smp_row(16'hFFFF, 32'd0, 32'd1, 32'd1502));
        rows.push_back(smp_row(16'd100, 32'd0, 32'd1, 32'd1503));
        // negative absolute count, timer starts just before the time wrap
        rows.push_back(smp_row(16'd4000, 32'hFFFF_FFFC, 32'hFFFF_FFFC, 32'hFFFF_FF00));
        rows.push_back(cfg_row(REG_AUTO_DISABLE, 32'd1));
        rows.push_back(cfg_row(REG_SETTLE_WINDOW, 32'd300));
        // window runs out across the time wrap: disable, then idle, then resync
        rows.push_back(smp_row(16'd4000, 32'hFFFF_FFFC, 32'hFFFF_FFFC, 32'h0000_0100));
        rows.push_back(smp_row(16'd4000, 32'hFFFF_FFFC, 32'hFFFF_FFFC, 32'h0000_0200));
        rows.push_back(smp_row(16'd4001, 32'd9, 32'd77, 32'h0000_0300));
        // zero steps per revolution and counts below the minimum
        rows.push_back(cfg_row(REG_STEPS_PER_REV, 32'd0));
        rows.push_back(cfg_row(REG_ENCODER_COUNTS, 32'd0));
        rows.push_back(smp_row(16'd1, 32'd5, 32'd6, 32'h0000_0400));
        rows.push_back(smp_row(16'd0, 32'd0, 32'd1, 32'h0000_0401));
        // numeric registers at their top values, initial sync off, counts above the maximum
        rows.push_back(cfg_row(REG_ENCODER_COUNTS, 32'h0001_FFFF));
        rows.push_back(cfg_row(REG_STEPS_PER_REV, 32'h0000_FFFF));
        rows.push_back(cfg_row(REG_CORR_THRESHOLD, 32'h0000_FFFF));
        rows.push_back(cfg_row(REG_CORR_LIMIT, 32'h000F_FFFF));
        rows.push_back(cfg_row(REG_SETTLE_WINDOW, 32'hFFFF_FFFF));
        rows.push_back(cfg_row(REG_INITIAL_SYNC, 32'd0));
        rows.push_back(smp_row(16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        rows.push_back(smp_row(16'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0));
        rows.push_back(smp_row(16'h8000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        // zero threshold and zero maximum
        rows.push_back(cfg_row(REG_CORR_THRESHOLD, 32'd0));
        rows.push_back(cfg_row(REG_CORR_LIMIT, 32'd0));
        rows.push_back(smp_row(16'h8000, 32'd98302, 32'd0, 32'd5));
        rows.push_back(smp_row(16'h8000, 32'd98301, 32'd0, 32'd6));

        // reset
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part, no idling
        for (i = 0; i < rows.size(); i++)
        begin
            if (rows[i].is_cfg)
            begin
                drain();
                write_reg(rows[i].addr, rows[i].data);
            end
            else
            begin
                want = predict_correction(rows[i].sample);
                if (rows[i].typed)
                begin
                    want = rows[i].want;
                end
                send_sample(rows[i].sample, want);
            end
        end

        // random phases, each with its own register setting and idling
        for (phase = 0; phase < PHASES; phase++)
        begin
            drain();
            set_phase_config();
            case (phase % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 75;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 75;
                end
                default:
                begin
                    idle_pct  = 12;
                    stall_pct = 12;
                end
            endcase
            // long receiver hold-off while samples keep coming
            if (phase == 4)
            begin
                hold_req = 1'b1;
            end
            run_phase(PHASE_ITEMS);
        end

        drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("stepper_encoder_position_correction_core: match");
        end
        else
        begin
            $display("stepper_encoder_position_correction_core: mismatch");
        end
        $finish;
    end

endmodule
